FILE: hdl/frustum_box_sphere_culler_unit_assert.svh
// Assertion macros for the frustum culler.
// Depends on nothing; the including module must have clk and an active-low rst_n.
`ifndef FRUSTUM_BOX_SPHERE_CULLER_UNIT_ASSERT_SVH
`define FRUSTUM_BOX_SPHERE_CULLER_UNIT_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define FBSC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define FBSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fbsc_pkg.sv
// Types and constants for the six-plane frustum culler.
// No dependencies.
package fbsc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;
  localparam int NORM_W     = 16;   // plane normal component, signed Q1.14
  localparam int DOFS_W     = 16;   // plane offset d, signed Q11.4
  localparam int FRAC_SHIFT = 14;   // aligns Q11.4 terms with Q1.14 * Q11.4 products
  localparam int PADDR_W    = 6;
  localparam int PDATA_W    = 64;
  localparam int REG_IDX_W  = 3;

  localparam logic [NUM_PLANES-1:0] VALID_MASK_RST = '1;

  typedef enum logic [1:0] {
    MODE_ISECT_BOX      = 2'd0,
    MODE_CONTAIN_BOX    = 2'd1,
    MODE_CONTAIN_POINT  = 2'd2,
    MODE_CONTAIN_SPHERE = 2'd3
  } mode_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PLANE_NEAR   = 3'd0,
    REG_PLANE_FAR    = 3'd1,
    REG_PLANE_LEFT   = 3'd2,
    REG_PLANE_RIGHT  = 3'd3,
    REG_PLANE_TOP    = 3'd4,
    REG_PLANE_BOTTOM = 3'd5,
    REG_VALID_MASK   = 3'd6
  } reg_idx_t;

endpackage

FILE: hdl/frustum_box_sphere_culler_unit.sv
// Six-plane view frustum culler: box, point and sphere tests, per-batch counts.
// Depends on fbsc_pkg and frustum_box_sphere_culler_unit_assert.svh.
`include "frustum_box_sphere_culler_unit_assert.svh"

// Usage
//   Input channel (in_valid/in_ready): one beat per object, carrying the test
//   mode, box min/max corners (or point / sphere center in min_*), the sphere
//   radius, an object index and a batch_last flag.
//   Result channel (out_valid/out_ready): one beat per object, in order, with
//   the visible flag and the running visible / culled totals for the batch.
//   The beat that carries result_last holds the final totals; both counters
//   then restart at zero. Counts saturate at MAX_BATCH.
//   Config port (APB-style, pready tied high): planes near, far, left, right,
//   top, bottom at 8*i (a,b,c Q1.14 in bits 47:0, d Q11.4 in bits 63:48) and
//   the plane valid mask at 0x30. Write only while the block is drained.
//   Throughput: one object per cycle while out_ready is high. An accepted
//   object passes through the input, product and result registers in that
//   order, and out_valid rises when it reaches the result register; the
//   product register holds the 18 normal*coordinate multiplies, the result stage the four-term sums and compares.
//   Stall: when out_ready is low, the three stages fill and in_ready drops;
//   nothing is lost or duplicated.
//   Reset (rst_n low, synchronous): pipeline empties, planes clear to zero,
//   valid mask sets to all ones, counters clear.
module frustum_box_sphere_culler_unit #(
  parameter int MAX_BATCH  = 65536,
  parameter int COORD_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  fbsc_pkg::mode_t                        in_mode,
  input  logic signed [COORD_BITS-1:0]           in_min_x,
  input  logic signed [COORD_BITS-1:0]           in_min_y,
  input  logic signed [COORD_BITS-1:0]           in_min_z,
  input  logic signed [COORD_BITS-1:0]           in_max_x,
  input  logic signed [COORD_BITS-1:0]           in_max_y,
  input  logic signed [COORD_BITS-1:0]           in_max_z,
  input  logic        [COORD_BITS-2:0]           in_radius,
  input  logic        [15:0]                     in_object_index,
  input  logic                                   in_batch_last,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic        [15:0]                     out_object_id,
  output logic                                   out_visible,
  output logic        [$clog2(MAX_BATCH+1)-1:0]  out_visible_total,
  output logic        [$clog2(MAX_BATCH+1)-1:0]  out_culled_total,
  output logic                                   out_result_last,
  // config port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic        [fbsc_pkg::PADDR_W-1:0]    paddr,
  input  logic        [fbsc_pkg::PDATA_W-1:0]    pwdata,
  output logic        [fbsc_pkg::PDATA_W-1:0]    prdata,
  output logic                                   pready
);
  import fbsc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BATCH + 1);
  localparam int PROD_W = NORM_W + COORD_BITS;
  // d*2^14 needs DOFS_W+FRAC_SHIFT bits; two guard bits for the 4-term sum
  localparam int SUM_W  = (PROD_W > DOFS_W + FRAC_SHIFT) ? PROD_W : DOFS_W + FRAC_SHIFT;
  localparam int DIST_W = SUM_W + 2;
  localparam int RAD_W  = COORD_BITS - 1;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BATCH);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PDATA_W-1:0]    plane_r [NUM_PLANES];
  logic [NUM_PLANES-1:0] valid_mask_r;
  reg_idx_t              cfg_idx;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        plane_r[p] <= '0;
      end
      valid_mask_r <= VALID_MASK_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PLANE_NEAR, REG_PLANE_FAR, REG_PLANE_LEFT,
        REG_PLANE_RIGHT, REG_PLANE_TOP, REG_PLANE_BOTTOM: begin
          plane_r[cfg_idx] <= pwdata;
        end
        REG_VALID_MASK: begin
          valid_mask_r <= pwdata[NUM_PLANES-1:0];
        end
        default: begin
          // unmapped address: write dropped
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PLANE_NEAR, REG_PLANE_FAR, REG_PLANE_LEFT,
      REG_PLANE_RIGHT, REG_PLANE_TOP, REG_PLANE_BOTTOM: begin
        prdata = plane_r[cfg_idx];
      end
      REG_VALID_MASK: begin
        prdata = {{(PDATA_W-NUM_PLANES){1'b0}}, valid_mask_r};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: each stage loads when it is empty or the one after it moves
  // ---------------------------------------------------------------------------
  logic s0_v_r, s1_v_r, out_valid_r;
  logic out_ld, s1_ld, s0_ld;

  assign out_ld   = !out_valid_r || out_ready;
  assign s1_ld    = !s1_v_r || out_ld;
  assign s0_ld    = !s0_v_r || s1_ld;
  assign in_ready = s0_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s0_ld)  s0_v_r      <= in_valid;
      if (s1_ld)  s1_v_r      <= s0_v_r;
      if (out_ld) out_valid_r <= s1_v_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------------
  mode_t                  s0_mode_r;
  logic signed [COORD_BITS-1:0] s0_lo_r [NUM_AXES];
  logic signed [COORD_BITS-1:0] s0_hi_r [NUM_AXES];
  logic [RAD_W-1:0]       s0_rad_r;
  logic [15:0]            s0_id_r;
  logic                   s0_last_r;

  always_ff @(posedge clk) begin
    if (s0_ld && in_valid) begin
      s0_mode_r  <= in_mode;
      s0_lo_r[0] <= in_min_x;
      s0_lo_r[1] <= in_min_y;
      s0_lo_r[2] <= in_min_z;
      s0_hi_r[0] <= in_max_x;
      s0_hi_r[1] <= in_max_y;
      s0_hi_r[2] <= in_max_z;
      s0_rad_r   <= in_radius;
      s0_id_r    <= in_object_index;
      s0_last_r  <= in_batch_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pick the corner per plane and axis, then one multiply each.
  // max(n*lo, n*hi) is n*max(lo,hi) for n >= 0 and n*min(lo,hi) for n < 0,
  // so the corner is chosen before the multiplier and the product is exact.
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] big  [NUM_AXES];
  logic signed [COORD_BITS-1:0] sml  [NUM_AXES];
  logic signed [PROD_W-1:0]     prod_nxt [NUM_PLANES][NUM_AXES];
  logic signed [PROD_W-1:0]     prod_r   [NUM_PLANES][NUM_AXES];
  mode_t                        s1_mode_r;
  logic [RAD_W-1:0]             s1_rad_r;
  logic [15:0]                  s1_id_r;
  logic                         s1_last_r;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      big[k] = (s0_lo_r[k] > s0_hi_r[k]) ? s0_lo_r[k] : s0_hi_r[k];
      sml[k] = (s0_lo_r[k] > s0_hi_r[k]) ? s0_hi_r[k] : s0_lo_r[k];
    end
  end

  always_comb begin
    logic signed [NORM_W-1:0]     n;
    logic signed [COORD_BITS-1:0] op;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        n = plane_r[p][NORM_W*k +: NORM_W];
        case (s0_mode_r)
          MODE_ISECT_BOX:   op = n[NORM_W-1] ? sml[k] : big[k];
          MODE_CONTAIN_BOX: op = n[NORM_W-1] ? big[k] : sml[k];
          default:          op = s0_lo_r[k];
        endcase
        prod_nxt[p][k] = PROD_W'(n * op);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld && s0_v_r) begin
      prod_r    <= prod_nxt;
      s1_mode_r <= s0_mode_r;
      s1_rad_r  <= s0_rad_r;
      s1_id_r   <= s0_id_r;
      s1_last_r <= s0_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: distances, threshold compare, batch counters
  // ---------------------------------------------------------------------------
  logic signed [DIST_W-1:0] thr;
  logic                     vis;

  assign thr = (s1_mode_r == MODE_CONTAIN_SPHERE) ?
               $signed({{(DIST_W-RAD_W-FRAC_SHIFT){1'b0}}, s1_rad_r, {FRAC_SHIFT{1'b0}}}) :
               '0;

  always_comb begin
    logic signed [DIST_W-1:0] plane_dist;
    logic [DOFS_W-1:0]        d;
    vis = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      d          = plane_r[p][PDATA_W-1 -: DOFS_W];
      plane_dist = $signed({{(DIST_W-DOFS_W-FRAC_SHIFT){d[DOFS_W-1]}}, d,
                            {FRAC_SHIFT{1'b0}}});
      for (int k = 0; k < NUM_AXES; k++) begin
        plane_dist = plane_dist + DIST_W'(prod_r[p][k]);
      end
      // plane cleared in the valid mask rejects everything
      if (!valid_mask_r[p] || (plane_dist < thr)) begin
        vis = 1'b0;
      end
    end
  end

  logic [CNT_W-1:0] vis_cnt_r, cul_cnt_r;
  logic [CNT_W-1:0] vis_tot_nxt, cul_tot_nxt;

  assign vis_tot_nxt = (vis && vis_cnt_r < CNT_MAX) ? vis_cnt_r + 1'b1 : vis_cnt_r;
  assign cul_tot_nxt = (!vis && cul_cnt_r < CNT_MAX) ? cul_cnt_r + 1'b1 : cul_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_cnt_r <= '0;
      cul_cnt_r <= '0;
    end else if (out_ld && s1_v_r) begin
      vis_cnt_r <= s1_last_r ? '0 : vis_tot_nxt;
      cul_cnt_r <= s1_last_r ? '0 : cul_tot_nxt;
    end
  end

  logic [15:0]      out_id_r;
  logic             out_vis_r;
  logic [CNT_W-1:0] out_vis_tot_r, out_cul_tot_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (out_ld && s1_v_r) begin
      out_id_r      <= s1_id_r;
      out_vis_r     <= vis;
      out_vis_tot_r <= vis_tot_nxt;
      out_cul_tot_r <= cul_tot_nxt;
      out_last_r    <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_object_id     = out_id_r;
  assign out_visible       = out_vis_r;
  assign out_visible_total = out_vis_tot_r;
  assign out_culled_total  = out_cul_tot_r;
  assign out_result_last   = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `FBSC_ASSERT_IMPL(a_cnt_sat, 1'b1, (vis_cnt_r <= CNT_MAX) && (cul_cnt_r <= CNT_MAX), "counter past MAX_BATCH")
  `FBSC_ASSERT_NEXT(a_last_clears, out_ld && s1_v_r && s1_last_r, (vis_cnt_r == '0) && (cul_cnt_r == '0), "counters not cleared after batch end")
  `FBSC_ASSERT_IMPL(a_vis_total, out_valid_r && out_vis_r, out_vis_tot_r != '0, "visible beat with zero visible total")
  `FBSC_ASSERT_NEXT(a_s1_hold, s1_v_r && !out_ld, s1_v_r && $stable(s1_id_r), "stalled product stage lost its item")
  `FBSC_ASSERT_IMPL(a_ready_full, !in_ready, s0_v_r && s1_v_r && out_valid_r && !out_ready, "input stalled with room in the pipeline")

endmodule
